FILE: hdl/entry_name_utf8_check_cp437_decode_macros.svh
// Assertion macros for the entry-name UTF-8 check / CP437 decode block.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef ENTRY_NAME_UTF8_CHECK_CP437_DECODE_MACROS_SVH
`define ENTRY_NAME_UTF8_CHECK_CP437_DECODE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U8CP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define U8CP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/u8cp_pkg.sv
// Shared types, constants and the CP437 to UTF-8 table.
// No dependencies; used by the validator, the serializer and the top level.
package u8cp_pkg;

   // UTF-8 lead and continuation byte classes
   localparam logic [7:0] LEAD2_LO  = 8'hC2;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD3_LO  = 8'hE0;
   localparam logic [7:0] LEAD3_HI  = 8'hEF;
   localparam logic [7:0] LEAD4_LO  = 8'hF0;
   localparam logic [7:0] LEAD4_HI  = 8'hF4;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;

   // code point limits
   localparam logic [20:0] CP_MIN2  = 21'h00080;
   localparam logic [20:0] CP_MIN3  = 21'h00800;
   localparam logic [20:0] CP_MIN4  = 21'h10000;
   localparam logic [20:0] SURR_LO  = 21'h0D800;
   localparam logic [20:0] SURR_HI  = 21'h0DFFF;
   localparam logic [20:0] CP_MAX   = 21'h10FFFF;

   // sequence lengths, counted as continuation bytes
   localparam logic [1:0] SEQ_NONE = 2'd0;
   localparam logic [1:0] SEQ_TWO  = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR = 2'd3;

   // UTF-8 forms of CP437 0x80..0xFF, big-endian; top byte zero means two bytes
   localparam logic [23:0] CP437_ROM [128] = '{
      24'hC387, 24'hC3BC, 24'hC3A9, 24'hC3A2, 24'hC3A4, 24'hC3A0, 24'hC3A5, 24'hC3A7,
      24'hC3AA, 24'hC3AB, 24'hC3A8, 24'hC3AF, 24'hC3AE, 24'hC3AC, 24'hC384, 24'hC385,
      24'hC389, 24'hC3A6, 24'hC386, 24'hC3B4, 24'hC3B6, 24'hC3B2, 24'hC3BB, 24'hC3B9,
      24'hC3BF, 24'hC396, 24'hC39C, 24'hC2A2, 24'hC2A3, 24'hC2A5, 24'hE282A7, 24'hC692,
      24'hC3A1, 24'hC3AD, 24'hC3B3, 24'hC3BA, 24'hC3B1, 24'hC391, 24'hC2AA, 24'hC2BA,
      24'hC2BF, 24'hE28C90, 24'hC2AC, 24'hC2BD, 24'hC2BC, 24'hC2A1, 24'hC2AB, 24'hC2BB,
      24'hE29691, 24'hE29692, 24'hE29693, 24'hE29482, 24'hE294A4, 24'hE295A1, 24'hE295A2,
      24'hE29596,
      24'hE29595, 24'hE295A3, 24'hE29591, 24'hE29597, 24'hE2959D, 24'hE2959C, 24'hE2959B,
      24'hE29490,
      24'hE29494, 24'hE294B4, 24'hE294AC, 24'hE2949C, 24'hE29480, 24'hE294BC, 24'hE2959E,
      24'hE2959F,
      24'hE2959A, 24'hE29594, 24'hE295A9, 24'hE295A6, 24'hE295A0, 24'hE29590, 24'hE295AC,
      24'hE295A7,
      24'hE295A8, 24'hE295A4, 24'hE295A5, 24'hE29599, 24'hE29598, 24'hE29592, 24'hE29593,
      24'hE295AB,
      24'hE295AA, 24'hE29498, 24'hE2948C, 24'hE29688, 24'hE29684, 24'hE2968C, 24'hE29690,
      24'hE29680,
      24'hCEB1, 24'hC39F, 24'hCE93, 24'hCF80, 24'hCEA3, 24'hCF83, 24'hC2B5, 24'hCF84,
      24'hCEA6, 24'hCE98, 24'hCEA9, 24'hCEB4, 24'hE2889E, 24'hCF86, 24'hCEB5, 24'hE288A9,
      24'hE289A1, 24'hC2B1, 24'hE289A5, 24'hE289A4, 24'hE28CA0, 24'hE28CA1, 24'hC3B7,
      24'hE28988,
      24'hC2B0, 24'hE28899, 24'hC2B7, 24'hE2889A, 24'hE281BF, 24'hC2B2, 24'hE296A0,
      24'hC2A0
   };

   // one accepted input word plus the validator verdict for it
   typedef struct packed {
      logic [7:0] name_byte;
      logic       utf8_mode;
      logic       name_end;
      logic       name_error;
   } item_type;

   // validator status, watched by the top level
   typedef struct packed {
      logic name_error;
      logic seq_open;
      logic sticky;
   } val_status_type;

endpackage

FILE: hdl/u8cp_req_if.sv
// Input channel: one raw entry-name byte per word with mode and end marks.
// No dependencies.
interface u8cp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_byte;
   logic       utf8_mode;
   logic       name_end;

   modport source (output valid, name_byte, utf8_mode, name_end, input ready);
   modport sink   (input valid, name_byte, utf8_mode, name_end, output ready);
endinterface

FILE: hdl/u8cp_rsp_if.sv
// Result channel: one UTF-8 output byte per word with run and name marks.
// No dependencies.
interface u8cp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       name_done;
   logic       name_error;

   modport source (output valid, out_byte, run_end, name_done, name_error, input ready);
   modport sink   (input valid, out_byte, run_end, name_done, name_error, output ready);
endinterface

FILE: hdl/u8cp_validator.sv
// Strict UTF-8 validator: sequence state and sticky error flag per name.
// Depends on u8cp_pkg.
module u8cp_validator import u8cp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  logic [7:0]     name_byte,
   input  logic           utf8_mode,
   input  logic           name_end,
   output val_status_type status
);

   logic [1:0]  pend_ff, pend_in;
   logic [1:0]  seq_ff, seq_in;
   logic [20:0] cp_ff, cp_in;
   logic        sticky_ff, sticky_in;
   logic [20:0] cp_acc;
   logic [1:0]  pend_dec;
   logic        bad;
   logic        verdict;

   always_comb begin
      pend_in   = pend_ff;
      seq_in    = seq_ff;
      cp_in     = cp_ff;
      sticky_in = sticky_ff;
      bad       = 1'b0;
      cp_acc    = {cp_ff[14:0], name_byte[5:0]};
      pend_dec  = pend_ff - 2'd1;

      if (fire && utf8_mode) begin
         if (pend_ff == 2'd0) begin
            if (name_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
               seq_in  = SEQ_TWO;
               pend_in = SEQ_TWO;
               cp_in   = {16'd0, name_byte[4:0]};
            end else if (name_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
               seq_in  = SEQ_THREE;
               pend_in = SEQ_THREE;
               cp_in   = {17'd0, name_byte[3:0]};
            end else if (name_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
               seq_in  = SEQ_FOUR;
               pend_in = SEQ_FOUR;
               cp_in   = {18'd0, name_byte[2:0]};
            end else if (name_byte[7]) begin
               bad = 1'b1;
            end
         end else if ((name_byte & CONT_MASK) != CONT_TAG) begin
            bad = 1'b1;
         end else begin
            pend_in = pend_dec;
            cp_in   = cp_acc;
            if (pend_dec == 2'd0) begin
               // sequence complete: reject overlong, surrogate, out of range
               seq_in = SEQ_NONE;
               cp_in  = '0;
               bad    = ((seq_ff == SEQ_TWO)   && (cp_acc < CP_MIN2)) ||
                        ((seq_ff == SEQ_THREE) && (cp_acc < CP_MIN3)) ||
                        ((seq_ff == SEQ_FOUR)  && (cp_acc < CP_MIN4)) ||
                        ((cp_acc >= SURR_LO) && (cp_acc <= SURR_HI)) ||
                        (cp_acc > CP_MAX);
            end
         end
      end

      if (bad) begin
         sticky_in = 1'b1;
         pend_in   = 2'd0;
         seq_in    = SEQ_NONE;
         cp_in     = '0;
      end

      verdict = sticky_in | (pend_in != 2'd0);

      // end of name: clear for the next one
      if (fire && name_end) begin
         sticky_in = 1'b0;
         pend_in   = 2'd0;
         seq_in    = SEQ_NONE;
         cp_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 2'd0;
         seq_ff    <= SEQ_NONE;
         cp_ff     <= '0;
         sticky_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         seq_ff    <= seq_in;
         cp_ff     <= cp_in;
         sticky_ff <= sticky_in;
      end
   end

   assign status.name_error = verdict;
   assign status.seq_open   = (pend_ff != 2'd0);
   assign status.sticky     = sticky_ff;

endmodule

FILE: hdl/u8cp_serializer.sv
// CP437 expansion into a three-byte queue and the registered result stage.
// Depends on u8cp_pkg.
module u8cp_serializer import u8cp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       run_end,
   output logic       name_done,
   output logic       name_error
);

   logic [7:0]  q_ff [3];
   logic [7:0]  q_in [3];
   logic [1:0]  left_ff, left_in;
   logic        last_ff, last_in;
   logic        err_ff, err_in;
   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic        ore_ff, ore_in;
   logic        od_ff, od_in;
   logic        oe_ff, oe_in;
   logic [23:0] rom_word;
   logic        pop;

   assign rom_word = CP437_ROM[item.name_byte[6:0]];
   // move the queue head into the result register when it is free or draining
   assign pop      = (left_ff != 2'd0) && (!ov_ff || out_ready);
   assign in_ready = (left_ff == 2'd0) || ((left_ff == 2'd1) && pop);

   always_comb begin
      q_in    = q_ff;
      left_in = left_ff;
      last_in = last_ff;
      err_in  = err_ff;
      ov_in   = ov_ff;
      ob_in   = ob_ff;
      ore_in  = ore_ff;
      od_in   = od_ff;
      oe_in   = oe_ff;

      if (out_ready) begin
         ov_in = 1'b0;
      end

      if (pop) begin
         ov_in   = 1'b1;
         ob_in   = q_ff[0];
         ore_in  = (left_ff == 2'd1);
         od_in   = (left_ff == 2'd1) && last_ff;
         oe_in   = (left_ff == 2'd1) && last_ff && err_ff;
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         left_in = left_ff - 2'd1;
      end

      if (fire) begin
         last_in = item.name_end;
         err_in  = item.name_error;
         if (item.utf8_mode || !item.name_byte[7]) begin
            q_in[0] = item.name_byte;
            left_in = 2'd1;
         end else if (rom_word[23:16] != 8'h00) begin
            q_in[0] = rom_word[23:16];
            q_in[1] = rom_word[15:8];
            q_in[2] = rom_word[7:0];
            left_in = 2'd3;
         end else begin
            q_in[0] = rom_word[15:8];
            q_in[1] = rom_word[7:0];
            left_in = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
         ov_ff   <= 1'b0;
      end else begin
         left_ff <= left_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      last_ff <= last_in;
      err_ff  <= err_in;
      ob_ff   <= ob_in;
      ore_ff  <= ore_in;
      od_ff   <= od_in;
      oe_ff   <= oe_in;
   end

   assign out_valid  = ov_ff;
   assign out_byte   = ob_ff;
   assign run_end    = ore_ff;
   assign name_done  = od_ff;
   assign name_error = oe_ff;

endmodule

FILE: hdl/entry_name_utf8_check_cp437_decode.sv
// Top level of the entry-name UTF-8 check / CP437 decode block.
// Depends on u8cp_pkg, u8cp_req_if, u8cp_rsp_if, u8cp_validator, u8cp_serializer.
//
// Usage:
//   req_chan carries one raw byte of an archive entry name per word, with a mode
//   bit (1 = UTF-8, passed through and strictly validated; 0 = CP437, high bytes
//   expanded to 2 or 3 UTF-8 bytes) and a flag on the name's final byte.
//   rsp_chan carries one output byte per word; run_end marks the last byte made
//   from one input word, name_done the last byte of the name, and name_error
//   (valid only with name_done) reports a strict UTF-8 failure in the name.
// Timing:
//   A word is validated in the cycle it is accepted and its 1 to 3 bytes are
//   queued; each byte passes from the queue through the result register to
//   rsp_chan. The result register emits one byte per cycle while rsp_chan is
//   ready; an input word makes 1 byte for ASCII and UTF-8 mode, 2 or 3 for a
//   high CP437 byte. The next word is taken while the previous word's last
//   byte is being handed to the result register.
// Reset clears the validator state, empties the byte queue and clears the result valid flag.
// A stall on rsp_chan holds the result register; the queue behind it fills and
// req_chan.ready drops until the queue can drain again.
`include "entry_name_utf8_check_cp437_decode_macros.svh"

module entry_name_utf8_check_cp437_decode import u8cp_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   u8cp_req_if.sink   req_chan,
   u8cp_rsp_if.source rsp_chan
);

   logic           fire;
   logic           in_ready;
   val_status_type val_status;
   item_type       item;

   // accept a word when the queue has room for it
   assign req_chan.ready = in_ready;
   assign fire           = req_chan.valid && in_ready;

   u8cp_validator u_validator (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .name_byte (req_chan.name_byte),
      .utf8_mode (req_chan.utf8_mode),
      .name_end  (req_chan.name_end),
      .status    (val_status)
   );

   // bundle the word with its verdict for the queue
   assign item.name_byte  = req_chan.name_byte;
   assign item.utf8_mode  = req_chan.utf8_mode;
   assign item.name_end   = req_chan.name_end;
   assign item.name_error = val_status.name_error;

   u8cp_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item),
      .in_ready   (in_ready),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_byte   (rsp_chan.out_byte),
      .run_end    (rsp_chan.run_end),
      .name_done  (rsp_chan.name_done),
      .name_error (rsp_chan.name_error)
   );

   // error flag only travels with the end of a name
   `U8CP_ASSERT_NOW(a_err_only_on_done, rsp_chan.valid && rsp_chan.name_error, rsp_chan.name_done, "name_error without name_done")
   // validator starts each name clean
   `U8CP_ASSERT_NEXT(a_clear_after_end, fire && req_chan.name_end, !val_status.seq_open && !val_status.sticky, "validator state not cleared at name end")
   // bytes of one word follow without a gap
   `U8CP_ASSERT_NEXT(a_run_no_gap, rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_end, rsp_chan.valid, "gap inside an expanded run")

endmodule
